FILE: rtl/periodic_task_tick_scheduler_top_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_TOP_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PTTS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define PTTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ptts_pkg.sv
`default_nettype none

package ptts_pkg;

    localparam int CMD_W      = 3;
    localparam int ID_W       = 3;
    localparam int TIME_W     = 16;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W      = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_CREATE  = 3'd1,
        CMD_SUSPEND = 3'd2,
        CMD_RESUME  = 3'd3,
        CMD_DELETE  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/ptts_req_if.sv
`default_nettype none

interface ptts_req_if;
    import ptts_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] first_delay;

    modport source (output valid, output cmd, output task_id, output period,
                    output first_delay, input ready);
    modport sink   (input valid, input cmd, input task_id, input period,
                    input first_delay, output ready);
endinterface

`default_nettype wire

FILE: rtl/ptts_rsp_if.sv
`default_nettype none

interface ptts_rsp_if;
    import ptts_pkg::*;

    logic            valid;
    logic            ready;
    logic            fired;
    logic [ID_W-1:0] fired_task;
    logic            last;

    modport source (output valid, output fired, output fired_task, output last,
                    input ready);
    modport sink   (input valid, input fired, input fired_task, input last,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/ptts_ram.sv
`default_nettype none

module ptts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/periodic_task_tick_scheduler_top.sv
// Tick-driven periodic task scheduler. Non-tick requests (create, suspend,
// resume, delete) are taken without giving a response. A tick walks the
// MAX_TASKS slots in priority order, one slot per cycle while the response
// side does not stall, through the timer RAM's read-modify-write loop, then
// closes out in the finish state. Each due task yields one response (at
// most eight per tick, the final one flagged last); a tick with nothing due
// yields one response with fired low and last high. New requests are held
// off while a tick is in progress. Slot contents other than the valid mark
// are not reset.
`default_nettype none

`include "periodic_task_tick_scheduler_top_assert.svh"

module periodic_task_tick_scheduler_top #(
    parameter int MAX_TASKS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    ptts_req_if.sink   req,
    ptts_rsp_if.source rsp
);
    import ptts_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TIM_W = 2 * TIME_W;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ID_W-1:0]       pend_id_reg, pend_id_next;
    logic                  slot_valid_reg [MAX_TASKS];

    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  rsp_fired_reg, rsp_fired_next;
    logic [ID_W-1:0]       rsp_task_reg, rsp_task_next;
    logic                  rsp_last_reg, rsp_last_next;

    logic                  accept;
    logic                  id_ok;
    logic [IDX_W-1:0]      cmd_idx;
    logic                  out_free;
    logic                  emit;

    logic                  rdy_we, rdy_re;
    logic [IDX_W-1:0]      rdy_waddr, rd_addr;
    logic [0:0]            rdy_wdata, rdy_rdata;
    logic                  tim_we, tim_re;
    logic [IDX_W-1:0]      tim_waddr;
    logic [TIM_W-1:0]      tim_wdata, tim_rdata;

    logic                  cur_valid, active, due, report, need_out, advance, at_last;
    logic [TIME_W-1:0]     cur_period, cur_count;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign id_ok     = (7'(req.task_id) < 7'(MAX_TASKS));
    assign cmd_idx   = IDX_W'(req.task_id);
    assign out_free  = !rsp_valid_reg || rsp.ready;

    assign cur_valid  = slot_valid_reg[scan_idx_reg];
    assign cur_period = tim_rdata[TIM_W-1:TIME_W];
    assign cur_count  = tim_rdata[TIME_W-1:0];
    assign active     = cur_valid && rdy_rdata[0];
    assign due        = active && (cur_count == '0);
    assign report     = due && (cnt_reg < CNT_W'(MAX_RESULTS));
    // a new fire pushes out the one held back; the held one is the last candidate
    assign need_out   = report && (cnt_reg != '0);
    assign advance    = !need_out || out_free;
    assign at_last    = (scan_idx_reg == IDX_W'(MAX_TASKS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.cmd == CMD_TICK)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (advance && at_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        scan_idx_next  = scan_idx_reg;
        cnt_next       = cnt_reg;
        pend_id_next   = pend_id_reg;
        emit           = 1'b0;
        rsp_fired_next = rsp_fired_reg;
        rsp_task_next  = rsp_task_reg;
        rsp_last_next  = rsp_last_reg;
        rdy_we         = 1'b0;
        rdy_waddr      = cmd_idx;
        rdy_wdata      = 1'b0;
        tim_we         = 1'b0;
        tim_waddr      = cmd_idx;
        tim_wdata      = {req.period, req.first_delay};
        rdy_re         = 1'b0;
        tim_re         = 1'b0;
        rd_addr        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.cmd)
                        CMD_TICK:
                        begin
                            rdy_re        = 1'b1;
                            tim_re        = 1'b1;
                            rd_addr       = '0;
                            scan_idx_next = '0;
                            cnt_next      = '0;
                        end
                        CMD_CREATE:
                        begin
                            if (id_ok && !slot_valid_reg[cmd_idx])
                            begin
                                rdy_we    = 1'b1;
                                rdy_wdata = 1'b1;
                                tim_we    = 1'b1;
                            end
                        end
                        CMD_SUSPEND:
                        begin
                            rdy_we    = id_ok;
                            rdy_wdata = 1'b0;
                        end
                        CMD_RESUME:
                        begin
                            rdy_we    = id_ok;
                            rdy_wdata = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EVAL:
            begin
                if (advance)
                begin
                    tim_we    = active;
                    tim_waddr = scan_idx_reg;
                    tim_wdata = {cur_period,
                                 due ? cur_period - 1'b1 : cur_count - 1'b1};
                    if (report)
                    begin
                        pend_id_next = ID_W'(scan_idx_reg);
                        cnt_next     = cnt_reg + 1'b1;
                    end
                    if (need_out)
                    begin
                        emit           = 1'b1;
                        rsp_fired_next = 1'b1;
                        rsp_task_next  = pend_id_reg;
                        rsp_last_next  = 1'b0;
                    end
                    if (!at_last)
                    begin
                        // next slot's read overlaps this slot's write-back
                        rdy_re        = 1'b1;
                        tim_re        = 1'b1;
                        rd_addr       = scan_idx_reg + 1'b1;
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    rsp_fired_next = (cnt_reg != '0);
                    rsp_task_next  = (cnt_reg != '0) ? pend_id_reg : '0;
                    rsp_last_next  = 1'b1;
                end
            end
            default: ;
        endcase
        rsp_valid_next = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (accept && id_ok)
            begin
                if (req.cmd == CMD_CREATE)
                begin
                    slot_valid_reg[cmd_idx] <= 1'b1;
                end
                else if (req.cmd == CMD_DELETE)
                begin
                    slot_valid_reg[cmd_idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg   <= pend_id_next;
        rsp_fired_reg <= rsp_fired_next;
        rsp_task_reg  <= rsp_task_next;
        rsp_last_reg  <= rsp_last_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.fired      = rsp_fired_reg;
    assign rsp.fired_task = rsp_task_reg;
    assign rsp.last       = rsp_last_reg;

    ptts_ram #(
        .WIDTH (1),
        .DEPTH (MAX_TASKS)
    ) u_ready_ram (
        .clk   (clk),
        .we    (rdy_we),
        .waddr (rdy_waddr),
        .wdata (rdy_wdata),
        .re    (rdy_re),
        .raddr (rd_addr),
        .rdata (rdy_rdata)
    );

    ptts_ram #(
        .WIDTH (TIM_W),
        .DEPTH (MAX_TASKS)
    ) u_timer_ram (
        .clk   (clk),
        .we    (tim_we),
        .waddr (tim_waddr),
        .wdata (tim_wdata),
        .re    (tim_re),
        .raddr (rd_addr),
        .rdata (tim_rdata)
    );

    `PTTS_ASSERT_IMPL(a_cnt_max, 1'b1, cnt_reg <= CNT_W'(MAX_RESULTS),
        "more responses held than one tick may report")
    `PTTS_ASSERT_IMPL(a_emit_free, emit, !rsp_valid_reg || rsp.ready,
        "response overwritten while stalled")
    `PTTS_ASSERT_IMPL(a_idle_write, tim_we && state_reg == ST_IDLE,
        req.valid && req.cmd == CMD_CREATE, "timer RAM written outside create or tick")
    `PTTS_ASSERT_NEXT(a_finish_exit, state_reg == ST_FINISH && out_free,
        state_reg == ST_IDLE && rsp_valid_reg && rsp_last_reg,
        "tick close-out did not deliver final response")

endmodule

`default_nettype wire
